FILE: hw/rtl/mbc_pkg.sv
// Package for the modular binomial coefficient block: widths, reset value,
// sequencer state type and the request bundle of the shared modular multiplier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbc_pkg;

  localparam int unsigned MOD_BITS     = 31;
  localparam int unsigned ARG_BITS_DEF = 20;
  localparam int unsigned MM_B_BITS    = 32;
  localparam int unsigned MM_BITS_CYC  = 2;
  localparam logic [MOD_BITS-1:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_MULN,
    S_MULD,
    S_PWSET,
    S_PWMUL,
    S_PWSQ,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [MOD_BITS-1:0]  a;
    logic [MM_B_BITS-1:0] b;
  } mm_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mbc_if.sv
// Valid/ready channel interfaces of the modular binomial coefficient block.
// Depends on mbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mbc_in_if #(parameter int unsigned W = mbc_pkg::ARG_BITS_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] n;
  logic [W-1:0] k;
  modport source (output valid, output n, output k, input ready);
  modport sink   (input valid, input n, input k, output ready);
endinterface

interface mbc_out_if;
  logic                         valid;
  logic                         ready;
  logic [mbc_pkg::MOD_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface mbc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mbc_pkg::MOD_BITS-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/modular_binomial_coefficient_top.sv
// Top level: C(n,k) mod p via falling product, k! and a Fermat inverse.
// Depends on mbc_pkg, mbc_if and mbc_mulmod.
//
//   channel  dir  payload            handshake
//   in_ch    in   n, k (ARG_BITS)    valid/ready
//   out_ch   out  value (31 bits)    valid/ready
//   cfg_ch   in   data -> modulus    valid/ready, always ready
//
// Each modular multiply runs on the one shared multiplier, in 16 steps of two
// bits of b. An item with n >= k takes 2k + 1 + bits(p-2) + ones(p-2) + 1
// multiplies plus control states; n < k or p < 2 goes straight to the done
// state and returns 0. One item at a time; in_ch.ready only in idle. A finished
// value waits in an output register, and the next item is taken while it waits.
// Reset sets the modulus to 1000000007.
`timescale 1ns / 1ps
`default_nettype none

module modular_binomial_coefficient_top #(
  parameter int unsigned ARG_BITS = mbc_pkg::ARG_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mbc_in_if.sink      in_ch,
  mbc_out_if.source   out_ch,
  mbc_cfg_if.sink     cfg_ch
);

  localparam int unsigned MW = mbc_pkg::MOD_BITS;
  localparam int unsigned BW = mbc_pkg::MM_B_BITS;

  mbc_pkg::state_t state_r, state_nxt;

  logic [MW-1:0]       modulus_r;
  logic [ARG_BITS:0]   j_r;
  logic [ARG_BITS-1:0] cnt_r;
  logic [MW-1:0]       num_r, den_r, nmod_r, dmod_r;
  logic [MW-1:0]       e_r, acc_r, base_r, res_r;
  logic [MW-1:0]       out_value_r;
  logic                out_valid_r;
  logic                issued_r;

  mbc_pkg::mm_req_t    mm_req;
  logic                mm_done;
  logic [MW-1:0]       mm_result;

  logic                early_zero;
  logic                out_free;
  logic [MW:0]         ninc, dinc;

  assign early_zero = (modulus_r < MW'(2)) || (in_ch.n < in_ch.k);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign ninc       = {1'b0, nmod_r} + 1'b1;
  assign dinc       = {1'b0, dmod_r} + 1'b1;

  mbc_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .p      (modulus_r),
    .req    (mm_req),
    .done   (mm_done),
    .result (mm_result)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mbc_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = early_zero ? mbc_pkg::S_DONE : mbc_pkg::S_RED;
        end
      end
      mbc_pkg::S_RED: begin
        if (issued_r && mm_done) begin
          state_nxt = (cnt_r == '0) ? mbc_pkg::S_PWSET : mbc_pkg::S_MULN;
        end
      end
      mbc_pkg::S_MULN: begin
        if (issued_r && mm_done) state_nxt = mbc_pkg::S_MULD;
      end
      mbc_pkg::S_MULD: begin
        if (issued_r && mm_done) begin
          state_nxt = (cnt_r == ARG_BITS'(1)) ? mbc_pkg::S_PWSET : mbc_pkg::S_MULN;
        end
      end
      mbc_pkg::S_PWSET: state_nxt = mbc_pkg::S_PWMUL;
      mbc_pkg::S_PWMUL: begin
        if (e_r == '0) begin
          state_nxt = mbc_pkg::S_FIN;
        end else if (!e_r[0] || (issued_r && mm_done)) begin
          state_nxt = mbc_pkg::S_PWSQ;
        end
      end
      mbc_pkg::S_PWSQ: begin
        if (issued_r && mm_done) state_nxt = mbc_pkg::S_PWMUL;
      end
      mbc_pkg::S_FIN: begin
        if (issued_r && mm_done) state_nxt = mbc_pkg::S_DONE;
      end
      mbc_pkg::S_DONE: begin
        if (out_free) state_nxt = mbc_pkg::S_IDLE;
      end
      default: state_nxt = mbc_pkg::S_IDLE;
    endcase
  end

  // outputs and multiplier requests
  always_comb begin
    in_ch.ready  = (state_r == mbc_pkg::S_IDLE);
    cfg_ch.ready = 1'b1;
    out_ch.valid = out_valid_r;
    out_ch.value = out_value_r;
    mm_req.start = 1'b0;
    mm_req.a     = base_r;
    mm_req.b     = BW'(base_r);
    unique case (state_r)
      mbc_pkg::S_RED: begin
        mm_req.start = !issued_r;
        mm_req.a     = MW'(1);
        mm_req.b     = BW'(j_r);
      end
      mbc_pkg::S_MULN: begin
        mm_req.start = !issued_r;
        mm_req.a     = num_r;
        mm_req.b     = BW'(nmod_r);
      end
      mbc_pkg::S_MULD: begin
        mm_req.start = !issued_r;
        mm_req.a     = den_r;
        mm_req.b     = BW'(dmod_r);
      end
      mbc_pkg::S_PWMUL: begin
        mm_req.start = !issued_r && e_r[0];
        mm_req.a     = acc_r;
        mm_req.b     = BW'(base_r);
      end
      mbc_pkg::S_PWSQ: begin
        mm_req.start = !issued_r;
      end
      mbc_pkg::S_FIN: begin
        mm_req.start = !issued_r;
        mm_req.a     = num_r;
        mm_req.b     = BW'(acc_r);
      end
      default: begin
        mm_req.start = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbc_pkg::S_IDLE;
      modulus_r   <= mbc_pkg::MOD_RESET;
      out_valid_r <= 1'b0;
      issued_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        modulus_r <= cfg_ch.data;
      end
      if (mm_req.start) begin
        issued_r <= 1'b1;
      end else if (mm_done) begin
        issued_r <= 1'b0;
      end
      if (state_r == mbc_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      mbc_pkg::S_IDLE: begin
        j_r    <= {1'b0, in_ch.n} - {1'b0, in_ch.k} + 1'b1;
        cnt_r  <= in_ch.k;
        num_r  <= MW'(1);
        den_r  <= MW'(1);
        dmod_r <= MW'(1);
        res_r  <= '0;
      end
      mbc_pkg::S_RED: begin
        if (issued_r && mm_done) nmod_r <= mm_result;
      end
      mbc_pkg::S_MULN: begin
        if (issued_r && mm_done) num_r <= mm_result;
      end
      mbc_pkg::S_MULD: begin
        if (issued_r && mm_done) begin
          den_r  <= mm_result;
          cnt_r  <= cnt_r - 1'b1;
          nmod_r <= (ninc == {1'b0, modulus_r}) ? '0 : ninc[MW-1:0];
          dmod_r <= (dinc == {1'b0, modulus_r}) ? '0 : dinc[MW-1:0];
        end
      end
      mbc_pkg::S_PWSET: begin
        e_r    <= modulus_r - MW'(2);
        acc_r  <= MW'(1);
        base_r <= den_r;
      end
      mbc_pkg::S_PWMUL: begin
        if (issued_r && mm_done) acc_r <= mm_result;
      end
      mbc_pkg::S_PWSQ: begin
        if (issued_r && mm_done) begin
          base_r <= mm_result;
          e_r    <= e_r >> 1;
        end
      end
      mbc_pkg::S_FIN: begin
        if (issued_r && mm_done) res_r <= mm_result;
      end
      mbc_pkg::S_DONE: begin
        if (out_free) out_value_r <= res_r;
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  a_done_requested : assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> issued_r)
    else $error("multiplier result without a request");

  a_valid_modulus : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbc_pkg::S_RED) |-> (modulus_r >= MW'(2)))
    else $error("product loop entered with modulus below two");

  a_out_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_value_r < modulus_r) || (out_value_r == '0))
    else $error("result not reduced");

endmodule

`default_nettype wire

FILE: hw/rtl/mbc_mulmod.sv
// Shared modular multiplier: a * b mod p, interleaved shift-add-reduce,
// MM_BITS_CYC bits of b per cycle, requires a < p. Depends on mbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbc_mulmod (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [mbc_pkg::MOD_BITS-1:0] p,
  input  wire mbc_pkg::mm_req_t             req,
  output logic                              done,
  output logic [mbc_pkg::MOD_BITS-1:0]      result
);

  localparam int unsigned MW    = mbc_pkg::MOD_BITS;
  localparam int unsigned BW    = mbc_pkg::MM_B_BITS;
  localparam int unsigned TW    = MW + 3;
  localparam int unsigned ITERS = BW / mbc_pkg::MM_BITS_CYC;
  localparam int unsigned CW    = $clog2(ITERS + 1);

  logic [MW-1:0] acc_r, acc_nxt;
  logic [MW-1:0] a_r;
  logic [BW-1:0] b_r, b_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  always_comb begin
    logic [TW-1:0] t_v;
    logic [TW-1:0] t1_v;
    logic [TW-1:0] t2_v;
    acc_nxt = acc_r;
    b_nxt   = b_r;
    for (int i = 0; i < int'(mbc_pkg::MM_BITS_CYC); i++) begin
      t_v  = {2'b00, acc_nxt, 1'b0} + (b_nxt[BW-1] ? TW'(a_r) : '0);
      t1_v = t_v - TW'(p);
      t2_v = t_v - TW'({p, 1'b0});
      if (!t2_v[TW-1]) begin
        acc_nxt = t2_v[MW-1:0];
      end else if (!t1_v[TW-1]) begin
        acc_nxt = t1_v[MW-1:0];
      end else begin
        acc_nxt = t_v[MW-1:0];
      end
      b_nxt = {b_nxt[BW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ITERS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      a_r   <= req.a;
      b_r   <= req.b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= b_nxt;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

  a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("multiplier started while busy");

  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("done without a finished operation");

  a_rose_start : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(req.start))
    else $error("multiplier busy without a start");

endmodule

`default_nettype wire
